// ===== rtl/kced_pkg.sv =====
// shared types, constants and window helpers for the kirsch edge detector
package kced_pkg;

   localparam int PIX_W             = 8;
   localparam int COORD_W           = 12;
   localparam int CFG_W             = 13;
   localparam int DEFAULT_MAX_WIDTH = 4096;
   localparam int HEIGHT_LIMIT      = 4096;
   localparam int JQ_DEPTH          = 4;
   localparam int JQ_CNT_W          = 3;
   localparam int OQ_DEPTH          = 8;
   localparam int OQ_CNT_W          = 4;

   // configuration register indexes
   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] REG_BORDER_MODE  = 2'd2;
   localparam logic [1:0] REG_THRESHOLD    = 2'd3;

   // reset values of the registers
   localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 13'd640;
   localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 13'd480;
   localparam logic [1:0]       RST_BORDER_MODE  = 2'd0;
   localparam logic [7:0]       RST_THRESHOLD    = 8'd150;

   // border padding codes
   localparam logic [1:0] BORDER_REFLECT   = 2'd0;
   localparam logic [1:0] BORDER_REPLICATE = 2'd1;

   // result slots of one job: bit 1 right border column, bit 0 bottom row
   localparam logic [1:0] SLOT_MAIN         = 2'd0;
   localparam logic [1:0] SLOT_BOTTOM       = 2'd1;
   localparam logic [1:0] SLOT_RIGHT        = 2'd2;
   localparam logic [1:0] SLOT_RIGHT_BOTTOM = 2'd3;

   typedef logic [PIX_W-1:0] pix_type;
   typedef pix_type [2:0]    col_type;   // rows top, middle, bottom
   typedef col_type [2:0]    win_type;   // columns left, middle, right

   typedef struct packed {
      logic [CFG_W-1:0] frame_width;
      logic [CFG_W-1:0] frame_height;
      logic [1:0]       border_mode;
      logic [7:0]       threshold;
   } cfg_type;

   typedef struct packed {
      win_type            win;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               top;
      logic               left;
      logic               last_row;
      logic               last_col;
   } job_type;

   typedef struct packed {
      logic [7:0]         edge_value;
      logic               edge_flag;
      logic [COORD_W-1:0] out_x;
      logic [COORD_W-1:0] out_y;
      logic               run_last;
      logic               frame_done;
   } res_type;

   // padded pixel per border mode
   function automatic pix_type pad_pix(pix_type refl, pix_type repl, logic [1:0] mode);
      pix_type p;
      case (mode)
         BORDER_REFLECT:   p = refl;
         BORDER_REPLICATE: p = repl;
         default:          p = '0;
      endcase
      return p;
   endfunction

   // rows of one window column, centered on the middle or bottom row
   function automatic col_type rows_of(col_type c, logic top, logic bottom,
                                       logic [1:0] mode);
      col_type t;
      if (bottom) begin
         t[0] = c[1];
         t[1] = c[2];
         t[2] = pad_pix(c[1], c[2], mode);
      end else begin
         t[0] = top ? pad_pix(c[2], c[1], mode) : c[0];
         t[1] = c[1];
         t[2] = c[2];
      end
      return t;
   endfunction

endpackage

// ===== rtl/kirsch_compass_edge_detector.sv =====
// top level: configuration registers, front end, job queue and back end
// the first result of a pixel passes the second front stage, job queue, kernel pipeline
//   and result queue; further results of a pixel follow one per cycle while the result
//   queue has room; intake: one pixel per cycle while the job queue has room; all results
//   share one kernel pipeline, so end-of-row and last-row pixels (2-4 results) slow intake
// the line store reads one column per pixel and writes it back in the next cycle
// reset: synchronous, clears counters, window, queues; registers return to defaults
module kirsch_compass_edge_detector #(
   parameter int MAX_WIDTH = kced_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  logic [kced_pkg::PIX_W-1:0]       req_pixel,
   input  logic                             req_start_of_frame,
   output logic                             empty,
   input  logic                             pop,
   output logic [7:0]                       rsp_edge_value,
   output logic                             rsp_edge_flag,
   output logic [kced_pkg::COORD_W-1:0]     rsp_out_x,
   output logic [kced_pkg::COORD_W-1:0]     rsp_out_y,
   output logic                             rsp_run_last,
   output logic                             rsp_frame_done,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [1:0]                       csr_index,
   input  logic [kced_pkg::CFG_W-1:0]       csr_data
);

   kced_pkg::cfg_type               cfg_ff;
   logic                            job_push, jq_pop, jq_valid;
   kced_pkg::job_type               job, jq_job;
   logic [kced_pkg::JQ_CNT_W-1:0]   jq_count;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= kced_pkg::RST_FRAME_WIDTH;
         cfg_ff.frame_height <= kced_pkg::RST_FRAME_HEIGHT;
         cfg_ff.border_mode  <= kced_pkg::RST_BORDER_MODE;
         cfg_ff.threshold    <= kced_pkg::RST_THRESHOLD;
      end else if (csr_valid) begin
         case (csr_index)
            kced_pkg::REG_FRAME_WIDTH:  cfg_ff.frame_width  <= csr_data;
            kced_pkg::REG_FRAME_HEIGHT: cfg_ff.frame_height <= csr_data;
            kced_pkg::REG_BORDER_MODE:  cfg_ff.border_mode  <= csr_data[1:0];
            kced_pkg::REG_THRESHOLD:    cfg_ff.threshold    <= csr_data[7:0];
            default:                    cfg_ff              <= cfg_ff;
         endcase
      end
   end

   kced_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .push               (push),
      .full               (full),
      .req_pixel          (req_pixel),
      .req_start_of_frame (req_start_of_frame),
      .jq_count           (jq_count),
      .job_push           (job_push),
      .job                (job)
   );

   kced_jobq u_jobq (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (job_push),
      .wr_job   (job),
      .rd_en    (jq_pop),
      .rd_valid (jq_valid),
      .rd_job   (jq_job),
      .count    (jq_count)
   );

   kced_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .jq_valid       (jq_valid),
      .jq_job         (jq_job),
      .jq_pop         (jq_pop),
      .pop            (pop),
      .empty          (empty),
      .rsp_edge_value (rsp_edge_value),
      .rsp_edge_flag  (rsp_edge_flag),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_run_last   (rsp_run_last),
      .rsp_frame_done (rsp_frame_done)
   );

endmodule

// ===== rtl/kced_front.sv =====
// front end: position counters, line store and window, one job per pixel with nonzero x and y
module kced_front #(
   parameter int MAX_WIDTH = kced_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  kced_pkg::cfg_type                    cfg,
   input  logic                                 push,
   output logic                                 full,
   input  logic [kced_pkg::PIX_W-1:0]           req_pixel,
   input  logic                                 req_start_of_frame,
   input  logic [kced_pkg::JQ_CNT_W-1:0]        jq_count,
   output logic                                 job_push,
   output kced_pkg::job_type                    job
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = AW + 1;
   localparam int HW = kced_pkg::CFG_W;
   localparam int PW = kced_pkg::PIX_W;

   logic                 accept;
   logic [WW-1:0]        w_eff;
   logic [HW-1:0]        h_eff;
   logic [AW-1:0]        x, col_ff, col_in;
   logic [kced_pkg::COORD_W-1:0] y, row_ff, row_in;
   logic [WW-1:0]        x_next;
   logic [HW-1:0]        y_next;

   logic                 s_valid_ff;
   logic [AW-1:0]        s_x_ff;
   logic [kced_pkg::COORD_W-1:0] s_y_ff;
   logic [PW-1:0]        s_px_ff;
   logic                 s_emit_ff, s_top_ff, s_left_ff, s_last_row_ff, s_last_col_ff;

   logic [2*PW-1:0]      line_mem [MAX_WIDTH];
   logic [2*PW-1:0]      rd_mem_ff, fwd_data_ff, rd_word, wr_word;
   logic                 fwd_ff;
   kced_pkg::win_type    win_ff, win_in;

   assign accept = push && !full;
   // keep room in the job queue for the item in the second stage
   assign full = (jq_count + kced_pkg::JQ_CNT_W'(s_valid_ff))
                 >= kced_pkg::JQ_CNT_W'(kced_pkg::JQ_DEPTH);

   // clamp frame size
   always_comb begin
      if (32'(cfg.frame_width) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else if (cfg.frame_width < 13'd3) begin
         w_eff = WW'(3);
      end else begin
         w_eff = WW'(cfg.frame_width);
      end
      if (32'(cfg.frame_height) > kced_pkg::HEIGHT_LIMIT) begin
         h_eff = HW'(kced_pkg::HEIGHT_LIMIT);
      end else if (cfg.frame_height < 13'd3) begin
         h_eff = HW'(3);
      end else begin
         h_eff = cfg.frame_height;
      end
   end

   // position of the incoming pixel and counters after it
   always_comb begin
      x = col_ff;
      y = row_ff;
      if (req_start_of_frame) begin
         x = '0;
         y = '0;
      end
      if ({1'b0, x} >= w_eff) begin
         x = '0;
         y = y + 1'b1;
      end
      if ({1'b0, y} >= h_eff) begin
         y = '0;
      end
      x_next = {1'b0, x} + 1'b1;
      y_next = {1'b0, y} + 1'b1;
      col_in = x_next[AW-1:0];
      row_in = y;
      if (x_next >= w_eff) begin
         col_in = '0;
         row_in = (y_next >= h_eff) ? '0 : y_next[kced_pkg::COORD_W-1:0];
      end
   end

   // counters and second stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         s_valid_ff <= 1'b0;
      end else begin
         s_valid_ff <= accept;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   // second stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s_x_ff        <= x;
         s_y_ff        <= y;
         s_px_ff       <= req_pixel;
         s_emit_ff     <= (x != '0) && (y != '0);
         s_top_ff      <= (y == kced_pkg::COORD_W'(1));
         s_left_ff     <= (x == AW'(1));
         s_last_row_ff <= ({1'b0, y} == h_eff - 1'b1);
         s_last_col_ff <= ({1'b0, x} == w_eff - 1'b1);
         fwd_ff        <= s_valid_ff && (s_x_ff == x);
         fwd_data_ff   <= wr_word;
      end
   end

   // line store: older row in the upper byte, newer row in the lower byte
   always_ff @(posedge clock) begin
      if (s_valid_ff) begin
         line_mem[s_x_ff] <= wr_word;
      end
      if (accept) begin
         rd_mem_ff <= line_mem[x];
      end
   end

   assign rd_word = fwd_ff ? fwd_data_ff : rd_mem_ff;
   assign wr_word = {rd_word[PW-1:0], s_px_ff};

   // window shift
   always_comb begin
      win_in       = win_ff;
      win_in[0]    = win_ff[1];
      win_in[1]    = win_ff[2];
      win_in[2][0] = rd_word[2*PW-1:PW];
      win_in[2][1] = rd_word[PW-1:0];
      win_in[2][2] = s_px_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (s_valid_ff) begin
         win_ff <= win_in;
      end
   end

   // job to the back end
   assign job_push     = s_valid_ff && s_emit_ff;
   assign job.win      = win_in;
   assign job.x        = kced_pkg::COORD_W'(s_x_ff);
   assign job.y        = s_y_ff;
   assign job.top      = s_top_ff;
   assign job.left     = s_left_ff;
   assign job.last_row = s_last_row_ff;
   assign job.last_col = s_last_col_ff;

endmodule

// ===== rtl/kced_jobq.sv =====
// short job queue between front and back end
module kced_jobq (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  kced_pkg::job_type              wr_job,
   input  logic                           rd_en,
   output logic                           rd_valid,
   output kced_pkg::job_type              rd_job,
   output logic [kced_pkg::JQ_CNT_W-1:0]  count
);

   localparam int PTR_W = $clog2(kced_pkg::JQ_DEPTH);

   kced_pkg::job_type                entry_ff [kced_pkg::JQ_DEPTH];
   logic [PTR_W-1:0]                 wr_ptr_ff, rd_ptr_ff;
   logic [kced_pkg::JQ_CNT_W-1:0]    count_ff;
   logic                             do_rd;

   assign do_rd    = rd_en && (count_ff != '0);
   assign rd_valid = (count_ff != '0);
   assign rd_job   = entry_ff[rd_ptr_ff];
   assign count    = count_ff;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + kced_pkg::JQ_CNT_W'(wr_en)
                     - kced_pkg::JQ_CNT_W'(do_rd);
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_job;
      end
   end

endmodule

// ===== rtl/kced_back.sv =====
// back end: result sequencer, kirsch kernel pipeline and result queue
module kced_back (
   input  logic                               clock,
   input  logic                               reset,
   input  kced_pkg::cfg_type                  cfg,
   input  logic                               jq_valid,
   input  kced_pkg::job_type                  jq_job,
   output logic                               jq_pop,
   input  logic                               pop,
   output logic                               empty,
   output logic [7:0]                         rsp_edge_value,
   output logic                               rsp_edge_flag,
   output logic [kced_pkg::COORD_W-1:0]       rsp_out_x,
   output logic [kced_pkg::COORD_W-1:0]       rsp_out_y,
   output logic                               rsp_run_last,
   output logic                               rsp_frame_done
);

   localparam int OPTR_W = $clog2(kced_pkg::OQ_DEPTH);
   localparam int CW     = kced_pkg::COORD_W;

   typedef struct packed {
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      logic          run_last;
      logic          done;
   } meta_type;

   logic [1:0]                     slot_ff, slot_in, slot_nx;
   logic                           slot_end, issue;
   logic [kced_pkg::OQ_CNT_W-1:0]  occ;
   kced_pkg::col_type              cl, cm, cr, lt, mt, rt, rfirst;
   logic                           top_c, bot_c, lpad, rpad;
   kced_pkg::win_type              p_in;
   meta_type                       m_in;

   logic                           v1_ff, v2_ff, v3_ff;
   kced_pkg::win_type              p1_ff;
   meta_type                       m1_ff, m2_ff, m3_ff;
   logic [10:0]                    tot_in, tot2_ff;
   logic [9:0]                     s3_in [8];
   logic [9:0]                     s3_ff [8];
   logic [7:0]                     sat_in [8];
   logic [7:0]                     sat_ff [8];
   logic [7:0]                     mx01, mx23, mx45, mx67, mxa, mxb, mx;

   kced_pkg::res_type              oq_ff [kced_pkg::OQ_DEPTH];
   logic [OPTR_W-1:0]              owr_ff, ord_ff;
   logic [kced_pkg::OQ_CNT_W-1:0]  ocnt_ff;
   logic                           o_rd;
   kced_pkg::res_type              o_wr_data, o_head;

   // issue one result per cycle while the result queue has room for it
   assign occ   = ocnt_ff + kced_pkg::OQ_CNT_W'(v1_ff) + kced_pkg::OQ_CNT_W'(v2_ff)
                  + kced_pkg::OQ_CNT_W'(v3_ff);
   assign issue = jq_valid && (occ < kced_pkg::OQ_CNT_W'(kced_pkg::OQ_DEPTH));

   // next slot of the current job
   always_comb begin
      slot_nx  = kced_pkg::SLOT_MAIN;
      slot_end = 1'b1;
      case (slot_ff)
         kced_pkg::SLOT_MAIN: begin
            if (jq_job.last_row) begin
               slot_nx  = kced_pkg::SLOT_BOTTOM;
               slot_end = 1'b0;
            end else if (jq_job.last_col) begin
               slot_nx  = kced_pkg::SLOT_RIGHT;
               slot_end = 1'b0;
            end
         end
         kced_pkg::SLOT_BOTTOM: begin
            if (jq_job.last_col) begin
               slot_nx  = kced_pkg::SLOT_RIGHT;
               slot_end = 1'b0;
            end
         end
         kced_pkg::SLOT_RIGHT: begin
            if (jq_job.last_row) begin
               slot_nx  = kced_pkg::SLOT_RIGHT_BOTTOM;
               slot_end = 1'b0;
            end
         end
         default: begin
            slot_end = 1'b1;
         end
      endcase
      slot_in = slot_end ? kced_pkg::SLOT_MAIN : slot_nx;
   end

   assign jq_pop = issue && slot_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= kced_pkg::SLOT_MAIN;
      end else if (issue) begin
         slot_ff <= slot_in;
      end
   end

   // padded 3x3 neighborhood for the current slot
   always_comb begin
      bot_c = slot_ff[0];
      rpad  = slot_ff[1];
      top_c = jq_job.top && !bot_c;
      lpad  = jq_job.left && !rpad;
      if (rpad) begin
         cl = jq_job.win[1];
         cm = jq_job.win[2];
         cr = jq_job.win[2];
      end else begin
         cl = jq_job.win[0];
         cm = jq_job.win[1];
         cr = jq_job.win[2];
      end
      mt     = kced_pkg::rows_of(cm, top_c, bot_c, cfg.border_mode);
      rfirst = kced_pkg::rows_of(cr, top_c, bot_c, cfg.border_mode);
      if (lpad) begin
         for (int i = 0; i < 3; i++) begin
            lt[i] = kced_pkg::pad_pix(rfirst[i], mt[i], cfg.border_mode);
         end
      end else begin
         lt = kced_pkg::rows_of(cl, top_c, bot_c, cfg.border_mode);
      end
      if (rpad) begin
         for (int i = 0; i < 3; i++) begin
            rt[i] = kced_pkg::pad_pix(lt[i], mt[i], cfg.border_mode);
         end
      end else begin
         rt = rfirst;
      end
      p_in[0] = lt;
      p_in[1] = mt;
      p_in[2] = rt;
      m_in.x        = rpad ? jq_job.x : jq_job.x - 1'b1;
      m_in.y        = bot_c ? jq_job.y : jq_job.y - 1'b1;
      m_in.run_last = slot_end;
      m_in.done     = (slot_ff == kced_pkg::SLOT_RIGHT_BOTTOM);
   end

   // ring sums: each kernel is 8 * (three neighbors) - 3 * (ring total)
   always_comb begin
      tot_in = 11'(p1_ff[0][0]) + 11'(p1_ff[1][0]) + 11'(p1_ff[2][0])
             + 11'(p1_ff[0][1]) + 11'(p1_ff[2][1])
             + 11'(p1_ff[0][2]) + 11'(p1_ff[1][2]) + 11'(p1_ff[2][2]);
      s3_in[0] = 10'(p1_ff[0][0]) + 10'(p1_ff[1][0]) + 10'(p1_ff[2][0]);
      s3_in[1] = 10'(p1_ff[0][2]) + 10'(p1_ff[1][2]) + 10'(p1_ff[2][2]);
      s3_in[2] = 10'(p1_ff[1][0]) + 10'(p1_ff[2][0]) + 10'(p1_ff[2][1]);
      s3_in[3] = 10'(p1_ff[0][1]) + 10'(p1_ff[0][2]) + 10'(p1_ff[1][2]);
      s3_in[4] = 10'(p1_ff[2][0]) + 10'(p1_ff[2][1]) + 10'(p1_ff[2][2]);
      s3_in[5] = 10'(p1_ff[0][0]) + 10'(p1_ff[0][1]) + 10'(p1_ff[0][2]);
      s3_in[6] = 10'(p1_ff[2][1]) + 10'(p1_ff[2][2]) + 10'(p1_ff[1][2]);
      s3_in[7] = 10'(p1_ff[0][0]) + 10'(p1_ff[1][0]) + 10'(p1_ff[0][1]);
   end

   // absolute value and saturation of each response
   always_comb begin
      for (int j = 0; j < 8; j++) begin
         logic signed [14:0] resp;
         logic [14:0]        mag;
         resp = $signed(15'({s3_ff[j], 3'b000}))
              - $signed(15'({tot2_ff, 1'b0}) + 15'(tot2_ff));
         mag  = resp[14] ? 15'(-resp) : 15'(resp);
         sat_in[j] = (mag > 15'd255) ? 8'd255 : mag[7:0];
      end
   end

   // maximum of the eight
   always_comb begin
      mx01 = (sat_ff[0] > sat_ff[1]) ? sat_ff[0] : sat_ff[1];
      mx23 = (sat_ff[2] > sat_ff[3]) ? sat_ff[2] : sat_ff[3];
      mx45 = (sat_ff[4] > sat_ff[5]) ? sat_ff[4] : sat_ff[5];
      mx67 = (sat_ff[6] > sat_ff[7]) ? sat_ff[6] : sat_ff[7];
      mxa  = (mx01 > mx23) ? mx01 : mx23;
      mxb  = (mx45 > mx67) ? mx45 : mx67;
      mx   = (mxa > mxb) ? mxa : mxb;
      o_wr_data.edge_value = mx;
      o_wr_data.edge_flag  = (mx > cfg.threshold);
      o_wr_data.out_x      = m3_ff.x;
      o_wr_data.out_y      = m3_ff.y;
      o_wr_data.run_last   = m3_ff.run_last;
      o_wr_data.frame_done = m3_ff.done;
   end

   // pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      p1_ff   <= p_in;
      m1_ff   <= m_in;
      tot2_ff <= tot_in;
      s3_ff   <= s3_in;
      m2_ff   <= m1_ff;
      sat_ff  <= sat_in;
      m3_ff   <= m2_ff;
   end

   // result queue
   assign empty  = (ocnt_ff == '0);
   assign o_rd   = pop && !empty;
   assign o_head = oq_ff[ord_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ff  <= '0;
         ord_ff  <= '0;
         ocnt_ff <= '0;
      end else begin
         if (v3_ff) begin
            owr_ff <= owr_ff + 1'b1;
         end
         if (o_rd) begin
            ord_ff <= ord_ff + 1'b1;
         end
         ocnt_ff <= ocnt_ff + kced_pkg::OQ_CNT_W'(v3_ff) - kced_pkg::OQ_CNT_W'(o_rd);
      end
   end

   always_ff @(posedge clock) begin
      if (v3_ff) begin
         oq_ff[owr_ff] <= o_wr_data;
      end
   end

   assign rsp_edge_value = o_head.edge_value;
   assign rsp_edge_flag  = o_head.edge_flag;
   assign rsp_out_x      = o_head.out_x;
   assign rsp_out_y      = o_head.out_y;
   assign rsp_run_last   = o_head.run_last;
   assign rsp_frame_done = o_head.frame_done;

`ifndef ASSERT_OFF
   // results in flight never exceed the result queue
   a_credit: assert property (@(posedge clock) disable iff (reset)
      occ <= kced_pkg::OQ_CNT_W'(kced_pkg::OQ_DEPTH))
      else $error("result queue overcommitted");

   // a job in the middle of its results stays at the queue head
   a_mid_job: assert property (@(posedge clock) disable iff (reset)
      (slot_ff != kced_pkg::SLOT_MAIN) |-> jq_valid)
      else $error("job lost in the middle of its results");

   // no result enters a full result queue unless one is read out in the same cycle
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (ocnt_ff < kced_pkg::OQ_CNT_W'(kced_pkg::OQ_DEPTH)) || o_rd)
      else $error("result queue overflow");

   // the frame's last result always closes its run
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && m3_ff.done) |-> m3_ff.run_last)
      else $error("frame done without run last");
`endif

endmodule
